FILE: design/ppda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppda_pkg: shared definitions for the point pair distance and angle unit
// Field widths, pipeline depth, fixed-point constants and the CORDIC arc table.
// ----------------------------------------------------------------------------
package ppda_pkg;

    // Port field widths
    localparam int COORD_W = 29;               // coordinate, degrees * 2^20
    localparam int SEP_W   = 29;               // separation, degrees * 2^20
    localparam int HEAD_W  = 25;               // heading, degrees * 2^16

    // Internal widths
    localparam int DELTA_W = COORD_W + 1;      // signed coordinate difference
    localparam int MAG_W   = COORD_W;          // magnitude of a difference
    localparam int SQR_W   = 2 * MAG_W;        // one square
    localparam int SQ_W    = SQR_W + 2;        // sum of squares and root work words
    localparam int NV_W    = 32;               // vector component around normalization
    localparam int NM_W    = 31;               // larger magnitude, normalized into bit 30
    localparam int CV_W    = 35;               // vector component inside CORDIC
    localparam int ACC_W   = 34;               // angle accumulator, degrees * 2^24

    // Iteration counts
    localparam int SQRT_STEPS   = 30;          // one result bit per stage
    localparam int SQRT_TOP     = 2 * (SQRT_STEPS - 1); // exponent of the first trial bit
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_IDX_W   = 5;

    // Register stages after the difference stage, the same on both paths
    localparam int PIPE_DEPTH = SQRT_STEPS + 3;

    // Fixed-point constants
    localparam logic [SEP_W-1:0]         SEP_MAX     = 29'h1FFF_FFFF;
    localparam logic signed [ACC_W-1:0]  ACC_180     = 34'sd3019898880;
    localparam logic signed [ACC_W-1:0]  ACC_HALF    = 34'sd128;
    localparam int                       ACC_DROP    = 8;
    localparam logic signed [ACC_W-1:0]  ACC_HEAD_MAX = 34'sd11796480;
    localparam logic signed [HEAD_W-1:0] HEAD_180    = 25'sd11796480;
    localparam logic signed [HEAD_W-1:0] HEAD_90     = 25'sd5898240;
    localparam logic signed [HEAD_W-1:0] HEAD_ZERO   = 25'sd0;

    // atan(2^-i) in degrees * 2^24, rounded to nearest
    function automatic logic signed [ACC_W-1:0] arc_deg(input logic [STEP_IDX_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd754974720;
            5'd1:    v = 34'sd445687602;
            5'd2:    v = 34'sd235489088;
            5'd3:    v = 34'sd119537938;
            5'd4:    v = 34'sd60000934;
            5'd5:    v = 34'sd30029717;
            5'd6:    v = 34'sd15018523;
            5'd7:    v = 34'sd7509720;
            5'd8:    v = 34'sd3754917;
            5'd9:    v = 34'sd1877466;
            5'd10:   v = 34'sd938734;
            5'd11:   v = 34'sd469367;
            5'd12:   v = 34'sd234684;
            5'd13:   v = 34'sd117342;
            5'd14:   v = 34'sd58671;
            5'd15:   v = 34'sd29335;
            5'd16:   v = 34'sd14668;
            5'd17:   v = 34'sd7334;
            5'd18:   v = 34'sd3667;
            5'd19:   v = 34'sd1833;
            5'd20:   v = 34'sd917;
            5'd21:   v = 34'sd458;
            5'd22:   v = 34'sd229;
            5'd23:   v = 34'sd115;
            5'd24:   v = 34'sd57;
            5'd25:   v = 34'sd29;
            5'd26:   v = 34'sd14;
            5'd27:   v = 34'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/ppda_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppda_dist: Euclidean distance pipeline
// Squares, sum, a bit-per-stage integer square root, then round and saturate.
// ----------------------------------------------------------------------------
module ppda_dist
    import ppda_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_adv,
    input  wire logic signed [DELTA_W-1:0] i_dlat,
    input  wire logic signed [DELTA_W-1:0] i_dlon,
    output logic [SEP_W-1:0]               o_separation
);

    logic [SQR_W-1:0] r_a2, r_b2;
    logic [SQR_W-1:0] n_a2, n_b2;
    logic [SQ_W-1:0]  r_rt [0:SQRT_STEPS];
    logic [SQ_W-1:0]  r_rm [0:SQRT_STEPS];
    logic [SQ_W-1:0]  n_rt [1:SQRT_STEPS];
    logic [SQ_W-1:0]  n_rm [1:SQRT_STEPS];
    logic [SEP_W-1:0] r_sep, n_sep;

    // Square the magnitudes of both differences
    always_comb begin
        logic [DELTA_W-1:0] v_a, v_b;
        v_a  = i_dlat[DELTA_W-1] ? DELTA_W'(-i_dlat) : DELTA_W'(i_dlat);
        v_b  = i_dlon[DELTA_W-1] ? DELTA_W'(-i_dlon) : DELTA_W'(i_dlon);
        n_a2 = SQR_W'(v_a[MAG_W-1:0]) * SQR_W'(v_a[MAG_W-1:0]);
        n_b2 = SQR_W'(v_b[MAG_W-1:0]) * SQR_W'(v_b[MAG_W-1:0]);
    end

    // One root bit per stage: trial subtract, keep or drop
    always_comb begin
        logic [SQ_W-1:0] v_bit, v_try;
        v_bit = '0;
        v_try = '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            v_bit = SQ_W'(1) << (SQRT_TOP - 2 * k);
            v_try = r_rt[k] + v_bit;
            if (r_rm[k] >= v_try) begin
                n_rm[k+1] = r_rm[k] - v_try;
                n_rt[k+1] = (r_rt[k] >> 1) + v_bit;
            end else begin
                n_rm[k+1] = r_rm[k];
                n_rt[k+1] = r_rt[k] >> 1;
            end
        end
    end

    // Round half up from the remainder, then saturate
    always_comb begin
        logic [SQ_W-1:0] v_root;
        v_root = r_rt[SQRT_STEPS] + SQ_W'(r_rm[SQRT_STEPS] > r_rt[SQRT_STEPS]);
        if (v_root > SQ_W'(SEP_MAX)) begin
            n_sep = SEP_MAX;
        end else begin
            n_sep = v_root[SEP_W-1:0];
        end
    end

    // Advance every stage together
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a2    <= n_a2;
            r_b2    <= n_b2;
            r_rm[0] <= SQ_W'(r_a2) + SQ_W'(r_b2);
            r_rt[0] <= '0;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                r_rm[k] <= n_rm[k];
                r_rt[k] <= n_rt[k];
            end
            r_sep   <= n_sep;
        end
    end

    assign o_separation = r_sep;

endmodule
`default_nettype wire

FILE: design/ppda_angle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppda_angle: line angle pipeline
// Half-turn fold, three normalization stages, one CORDIC vectoring iteration
// per stage, then rounding, clamping and the exact axis cases.
// ----------------------------------------------------------------------------
module ppda_angle
    import ppda_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_adv,
    input  wire logic signed [DELTA_W-1:0] i_dlat,
    input  wire logic signed [DELTA_W-1:0] i_dlon,
    output logic signed [HEAD_W-1:0]       o_heading_degrees
);

    typedef struct packed {
        logic zero_lon;
        logic zero_lat;
        logic lat_neg;
        logic lon_pos;
    } t_spec;

    localparam int CD = CORDIC_STEPS;

    // Fold stage
    logic signed [NV_W-1:0]  r_p_x, r_p_y, n_p_x, n_p_y;
    logic [NM_W-1:0]         r_p_m, n_p_m;
    logic signed [ACC_W-1:0] r_p_acc, n_p_acc;
    t_spec                   n_spec;
    // Normalization stages
    logic signed [NV_W-1:0]  r_n1_x, r_n1_y, n_n1_x, n_n1_y;
    logic [NM_W-1:0]         r_n1_m, n_n1_m;
    logic signed [ACC_W-1:0] r_n1_acc;
    logic signed [NV_W-1:0]  r_n2_x, r_n2_y, n_n2_x, n_n2_y;
    logic [NM_W-1:0]         r_n2_m, n_n2_m;
    logic signed [ACC_W-1:0] r_n2_acc;
    logic signed [NV_W-1:0]  n_n3_x, n_n3_y;
    // CORDIC stages
    logic signed [CV_W-1:0]  r_cx [0:CD];
    logic signed [CV_W-1:0]  r_cy [0:CD];
    logic signed [ACC_W-1:0] r_ca [0:CD];
    logic signed [CV_W-1:0]  n_cx [1:CD];
    logic signed [CV_W-1:0]  n_cy [1:CD];
    logic signed [ACC_W-1:0] n_ca [1:CD];
    // Axis flags travel beside the data
    t_spec                   r_spec [1:PIPE_DEPTH-1];
    logic signed [HEAD_W-1:0] r_head, n_head;

    // Fold the left half-plane onto the right and pick the larger magnitude
    always_comb begin
        logic signed [NV_W-1:0] v_lat, v_lon, v_ay;
        v_lat   = NV_W'(i_dlat);
        v_lon   = NV_W'(i_dlon);
        n_p_x   = i_dlat[DELTA_W-1] ? -v_lat : v_lat;
        n_p_y   = i_dlat[DELTA_W-1] ? -v_lon : v_lon;
        v_ay    = n_p_y[NV_W-1] ? -n_p_y : n_p_y;
        n_p_m   = (n_p_x > v_ay) ? n_p_x[NM_W-1:0] : v_ay[NM_W-1:0];
        if (!i_dlat[DELTA_W-1]) begin
            n_p_acc = '0;
        end else if (!i_dlon[DELTA_W-1]) begin
            n_p_acc = ACC_180;
        end else begin
            n_p_acc = -ACC_180;
        end
        n_spec.zero_lon = (i_dlon == '0);
        n_spec.zero_lat = (i_dlat == '0);
        n_spec.lat_neg  = i_dlat[DELTA_W-1];
        n_spec.lon_pos  = !i_dlon[DELTA_W-1] && (i_dlon != '0);
    end

    // Normalize, first part: shift by 16 then 8
    always_comb begin
        n_n1_x = r_p_x;
        n_n1_y = r_p_y;
        n_n1_m = r_p_m;
        if (n_n1_m[NM_W-1 -: 16] == '0) begin
            n_n1_x = n_n1_x <<< 16;
            n_n1_y = n_n1_y <<< 16;
            n_n1_m = n_n1_m << 16;
        end
        if (n_n1_m[NM_W-1 -: 8] == '0) begin
            n_n1_x = n_n1_x <<< 8;
            n_n1_y = n_n1_y <<< 8;
            n_n1_m = n_n1_m << 8;
        end
    end

    // Normalize, second part: shift by 4 then 2
    always_comb begin
        n_n2_x = r_n1_x;
        n_n2_y = r_n1_y;
        n_n2_m = r_n1_m;
        if (n_n2_m[NM_W-1 -: 4] == '0) begin
            n_n2_x = n_n2_x <<< 4;
            n_n2_y = n_n2_y <<< 4;
            n_n2_m = n_n2_m << 4;
        end
        if (n_n2_m[NM_W-1 -: 2] == '0) begin
            n_n2_x = n_n2_x <<< 2;
            n_n2_y = n_n2_y <<< 2;
            n_n2_m = n_n2_m << 2;
        end
    end

    // Normalize, last part: shift by 1 if bit 30 is still clear
    always_comb begin
        n_n3_x = r_n2_x;
        n_n3_y = r_n2_y;
        if (!r_n2_m[NM_W-1]) begin
            n_n3_x = r_n2_x <<< 1;
            n_n3_y = r_n2_y <<< 1;
        end
    end

    // One vectoring rotation per stage, toward y = 0
    always_comb begin
        for (int k = 0; k < CD; k++) begin
            if (!r_cy[k][CV_W-1]) begin
                n_cx[k+1] = r_cx[k] + (r_cy[k] >>> k);
                n_cy[k+1] = r_cy[k] - (r_cx[k] >>> k);
                n_ca[k+1] = r_ca[k] + arc_deg(STEP_IDX_W'(k));
            end else begin
                n_cx[k+1] = r_cx[k] - (r_cy[k] >>> k);
                n_cy[k+1] = r_cy[k] + (r_cx[k] >>> k);
                n_ca[k+1] = r_ca[k] - arc_deg(STEP_IDX_W'(k));
            end
        end
    end

    // Round to degrees * 2^16, clamp, and apply the axis cases
    always_comb begin
        logic signed [ACC_W-1:0] v_h;
        t_spec                   v_s;
        v_s = r_spec[PIPE_DEPTH-1];
        v_h = (r_ca[CD] + ACC_HALF) >>> ACC_DROP;
        if (v_h > ACC_HEAD_MAX) begin
            v_h = ACC_HEAD_MAX;
        end else if (v_h < -ACC_HEAD_MAX) begin
            v_h = -ACC_HEAD_MAX;
        end
        if (v_s.zero_lon) begin
            n_head = v_s.lat_neg ? HEAD_180 : HEAD_ZERO;
        end else if (v_s.zero_lat) begin
            n_head = v_s.lon_pos ? HEAD_90 : -HEAD_90;
        end else begin
            n_head = v_h[HEAD_W-1:0];
        end
    end

    // Advance every stage together
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p_x    <= n_p_x;
            r_p_y    <= n_p_y;
            r_p_m    <= n_p_m;
            r_p_acc  <= n_p_acc;
            r_n1_x   <= n_n1_x;
            r_n1_y   <= n_n1_y;
            r_n1_m   <= n_n1_m;
            r_n1_acc <= r_p_acc;
            r_n2_x   <= n_n2_x;
            r_n2_y   <= n_n2_y;
            r_n2_m   <= n_n2_m;
            r_n2_acc <= r_n1_acc;
            r_cx[0]  <= CV_W'(n_n3_x);
            r_cy[0]  <= CV_W'(n_n3_y);
            r_ca[0]  <= r_n2_acc;
            for (int k = 1; k <= CD; k++) begin
                r_cx[k] <= n_cx[k];
                r_cy[k] <= n_cy[k];
                r_ca[k] <= n_ca[k];
            end
            r_spec[1] <= n_spec;
            for (int k = 2; k < PIPE_DEPTH; k++) begin
                r_spec[k] <= r_spec[k-1];
            end
            r_head   <= n_head;
        end
    end

    assign o_heading_degrees = r_head;

endmodule
`default_nettype wire

FILE: design/point_pair_distance_and_angle_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_pair_distance_and_angle_unit: distance and line angle of a point pair
// Top level: difference stage, the two arithmetic pipelines, output skid.
// ----------------------------------------------------------------------------
// The unit takes one point pair per clock while o_in_ready is high and
// returns one result per pair, in order. An accepted transaction passes
// one difference stage and 33 arithmetic stages, then enters the output
// register. The depth is set by the square root, which resolves one result
// bit per stage over 30 stages; the angle path (fold, three normalization
// stages, 28 CORDIC iterations, rounding) is built to the same depth. With
// the output taken every cycle the unit sustains one transaction per cycle.
// When the output stalls, one more result is caught in a skid register and
// the input then holds o_in_ready low until the output drains. The unit keeps
// no state between transactions; reset clears only the valid bits.
// ----------------------------------------------------------------------------
module point_pair_distance_and_angle_unit
    import ppda_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic signed [COORD_W-1:0] i_first_latitude,
    input  wire logic signed [COORD_W-1:0] i_first_longitude,
    input  wire logic signed [COORD_W-1:0] i_second_latitude,
    input  wire logic signed [COORD_W-1:0] i_second_longitude,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [SEP_W-1:0]               o_separation,
    output logic signed [HEAD_W-1:0]       o_heading_degrees
);

    logic [PIPE_DEPTH:0]       r_valid;
    logic                      w_adv, w_take, w_arrive;
    logic signed [DELTA_W-1:0] r_dlat, r_dlon;
    logic [SEP_W-1:0]          w_sep;
    logic signed [HEAD_W-1:0]  w_head;
    logic                      r_out_valid, r_skid_valid;
    logic [SEP_W-1:0]          r_out_sep, r_skid_sep;
    logic signed [HEAD_W-1:0]  r_out_head, r_skid_head;

    // Pipeline moves whenever the skid register is free
    assign w_adv    = !r_skid_valid;
    assign w_take   = r_out_valid && i_out_ready;
    assign w_arrive = w_adv && r_valid[PIPE_DEPTH];

    // Take the coordinate differences
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dlat <= DELTA_W'(i_second_latitude) - DELTA_W'(i_first_latitude);
            r_dlon <= DELTA_W'(i_second_longitude) - DELTA_W'(i_first_longitude);
        end
    end

    ppda_dist u_dist (
        .i_clk        (i_clk),
        .i_adv        (w_adv),
        .i_dlat       (r_dlat),
        .i_dlon       (r_dlon),
        .o_separation (w_sep)
    );

    ppda_angle u_angle (
        .i_clk             (i_clk),
        .i_adv             (w_adv),
        .i_dlat            (r_dlat),
        .i_dlon            (r_dlon),
        .o_heading_degrees (w_head)
    );

    // Valid bits and output/skid occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_valid <= {r_valid[PIPE_DEPTH-1:0], i_in_valid};
            end
            if (r_skid_valid) begin
                if (w_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_arrive) begin
                if (r_out_valid && !w_take) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output and skid data
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_sep  <= r_skid_sep;
                r_out_head <= r_skid_head;
            end
        end else if (w_arrive) begin
            if (r_out_valid && !w_take) begin
                r_skid_sep  <= w_sep;
                r_skid_head <= w_head;
            end else begin
                r_out_sep  <= w_sep;
                r_out_head <= w_head;
            end
        end
    end

    assign o_in_ready        = w_adv;
    assign o_out_valid       = r_out_valid;
    assign o_separation      = r_out_sep;
    assign o_heading_degrees = r_out_head;

    // Skid holds a result only behind an occupied output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // A held pipeline keeps its valid bits
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_valid))
        else $error("pipeline valid bits moved during a stall");

    // An accepted transaction enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_valid[0])
        else $error("accepted transaction missing from first stage");

    // Delivered heading stays within a half turn
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heading_degrees <= HEAD_180) && (o_heading_degrees >= -HEAD_180))
        else $error("heading outside half turn");

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for point_pair_distance_and_angle_unit
// Sends point pairs through the valid/ready input, predicts the separation
// and the CORDIC line angle of every accepted pair, and checks each result
// in order. Covers corner and axis cases, saturation, random traffic with
// random idling on both sides, and a long output hold-off that fills the unit.
// ----------------------------------------------------------------------------
module tb_top
    import ppda_pkg::*;
();

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 8;
    localparam int QUIET_LIMIT      = 2000;  // cycles with no transaction on either side
    localparam int FLUSH_CYCLES     = 50;
    localparam int PRINT_CAP        = 40;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int HOLD_OFF_PAIRS   = 80;
    localparam int PAIRS_PER_PHASE  = 375;

    localparam int COORD_MAX  = 2**(COORD_W-1) - 1;
    localparam int COORD_MIN  = -(2**(COORD_W-1));
    localparam int RANGE_EDGE = 180 * 2**20;

    localparam longint unsigned SEP_CEIL = (64'd1 << SEP_W) - 1;
    localparam longint HEAD_LIMIT    = 180 * 2**16;
    localparam longint HEAD_RIGHT    = 90 * 2**16;
    localparam longint ARC_HALF_TURN = longint'(180) << 24;
    localparam longint NORM_FLOOR    = longint'(1) << 30;
    localparam int     ARC_STEPS     = 28;

    // atan(2^-i) in degrees * 2^24; step i sits at bits [32*i +: 32]
    localparam logic [ARC_STEPS*32-1:0] ARC_TABLE = {
        32'd7,         32'd14,        32'd29,        32'd57,
        32'd115,       32'd229,       32'd458,       32'd917,
        32'd1833,      32'd3667,      32'd7334,      32'd14668,
        32'd29335,     32'd58671,     32'd117342,    32'd234684,
        32'd469367,    32'd938734,    32'd1877466,   32'd3754917,
        32'd7509720,   32'd15018523,  32'd30029717,  32'd60000934,
        32'd119537938, 32'd235489088, 32'd445687602, 32'd754974720
    };

    typedef struct {
        logic signed [COORD_W-1:0] lat0;
        logic signed [COORD_W-1:0] lon0;
        logic signed [COORD_W-1:0] lat1;
        logic signed [COORD_W-1:0] lon1;
        logic [SEP_W-1:0]          separation;
        logic signed [HEAD_W-1:0]  heading;
    } t_geometry;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] first_latitude;
    logic signed [COORD_W-1:0] first_longitude;
    logic signed [COORD_W-1:0] second_latitude;
    logic signed [COORD_W-1:0] second_longitude;
    logic                      out_valid;
    logic                      out_ready;
    logic [SEP_W-1:0]          separation;
    logic signed [HEAD_W-1:0]  heading_degrees;

    t_geometry awaited_geometry [$];

    bit feed_gaps_on;
    bit drain_gaps_on;
    int stall_request;
    int errors              = 0;
    int pairs_sent          = 0;
    int results_checked     = 0;
    int saturated           = 0;
    int backpressure_cycles = 0;
    int long_stalls         = 0;
    int quiet_cycles        = 0;

    point_pair_distance_and_angle_unit uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_first_latitude   (first_latitude),
        .i_first_longitude  (first_longitude),
        .i_second_latitude  (second_latitude),
        .i_second_longitude (second_longitude),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_separation       (separation),
        .o_heading_degrees  (heading_degrees)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Round-to-nearest square root of dlat^2 + dlon^2, saturated
    function automatic logic [SEP_W-1:0] rounded_separation(input longint dlat, dlon);
        longint unsigned a, b, rem, root, trial;
        a = (dlat < 0) ? -dlat : dlat;
        b = (dlon < 0) ? -dlon : dlon;
        rem = a * a + b * b;
        root = 0;
        trial = 64'h4000_0000_0000_0000;
        while (trial > rem) trial = trial >> 2;
        while (trial != 0) begin
            if (rem >= root + trial) begin
                rem = rem - (root + trial);
                root = (root >> 1) + trial;
            end else begin
                root = root >> 1;
            end
            trial = trial >> 2;
        end
        // rem is now s - root^2; round up past the midpoint
        if (rem > root) root = root + 1;
        if (root > SEP_CEIL) root = SEP_CEIL;
        return root[SEP_W-1:0];
    endfunction

    // atan2(dlon, dlat) in degrees * 2^16 by CORDIC vectoring
    function automatic logic signed [HEAD_W-1:0] line_heading(input longint dlat, dlon);
        longint x, y, acc, nx, ny, arc, h;
        int step;
        x = dlat;
        y = dlon;
        acc = 0;
        if (dlon == 0) begin
            h = (dlat < 0) ? HEAD_LIMIT : 0;
        end else if (dlat == 0) begin
            h = (dlon > 0) ? HEAD_RIGHT : -HEAD_RIGHT;
        end else begin
            // fold the left half plane over by half a turn
            if (x < 0) begin
                acc = (y >= 0) ? ARC_HALF_TURN : -ARC_HALF_TURN;
                x = -x;
                y = -y;
            end
            while (x < NORM_FLOOR && y < NORM_FLOOR && y > -NORM_FLOOR) begin
                x = x * 2;
                y = y * 2;
            end
            for (step = 0; step < ARC_STEPS; step++) begin
                arc = longint'(ARC_TABLE[step*32 +: 32]);
                if (y >= 0) begin
                    nx = x + (y >>> step);
                    ny = y - (x >>> step);
                    acc = acc + arc;
                end else begin
                    nx = x - (y >>> step);
                    ny = y + (x >>> step);
                    acc = acc - arc;
                end
                x = nx;
                y = ny;
            end
            h = (acc + 128) >>> 8;
            if (h > HEAD_LIMIT) h = HEAD_LIMIT;
            if (h < -HEAD_LIMIT) h = -HEAD_LIMIT;
        end
        return h[HEAD_W-1:0];
    endfunction

    function automatic t_geometry compute_geometry(
        input logic signed [COORD_W-1:0] lat0, lon0, lat1, lon1
    );
        t_geometry g;
        longint dlat, dlon;
        dlat = longint'(lat1) - longint'(lat0);
        dlon = longint'(lon1) - longint'(lon0);
        g.lat0 = lat0;
        g.lon0 = lon0;
        g.lat1 = lat1;
        g.lon1 = lon1;
        g.separation = rounded_separation(dlat, dlon);
        g.heading = line_heading(dlat, dlon);
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 16)) : 0;
    endfunction

    function automatic logic signed [COORD_W-1:0] in_range_coord();
        return COORD_W'(int'($urandom_range(0, 2 * RANGE_EDGE)) - RANGE_EDGE);
    endfunction

    function automatic logic signed [COORD_W-1:0] raw_coord();
        bit [31:0] r;
        r = $urandom();
        return r[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 6))
            0:       return COORD_W'(COORD_MIN);
            1:       return COORD_W'(COORD_MAX);
            2:       return COORD_W'(RANGE_EDGE);
            3:       return COORD_W'(-RANGE_EDGE);
            4:       return '0;
            5:       return COORD_W'(1);
            default: return COORD_W'(-1);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] small_offset(input int span);
        int amount;
        amount = int'($urandom_range(0, 1 << span));
        return COORD_W'($urandom_range(0, 1) ? amount : -amount);
    endfunction

    task automatic report_error(input string msg);
        errors++;
        // keep the log short when the unit is badly broken
        if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Offer one point pair after a random gap; hold it until accepted
    task automatic send_pair(input logic signed [COORD_W-1:0] lat0, lon0, lat1, lon1);
        int gap;
        gap = draw_gap(feed_gaps_on);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        first_latitude   = lat0;
        first_longitude  = lon0;
        second_latitude  = lat1;
        second_longitude = lon1;
        in_valid         = 1'b1;
        do @(posedge clk); while (!in_ready);
        awaited_geometry.insert(awaited_geometry.size(),
                                compute_geometry(lat0, lon0, lat1, lon1));
        pairs_sent++;
    endtask

    // Offer a pair given as plain integers
    task automatic send_coords(input int lat0, lon0, lat1, lon1);
        send_pair(COORD_W'(lat0), COORD_W'(lon0), COORD_W'(lat1), COORD_W'(lon1));
    endtask

    // Mostly in-range pairs, plus raw patterns, close pairs, axis pairs,
    // coincident pairs and corner values
    task automatic send_random_pair();
        logic signed [COORD_W-1:0] lat0, lon0, lat1, lon1;
        int pick, span;
        pick = $urandom_range(0, 9);
        lat0 = in_range_coord();
        lon0 = in_range_coord();
        lat1 = in_range_coord();
        lon1 = in_range_coord();
        case (pick)
            5: begin
                lat0 = raw_coord();
                lon0 = raw_coord();
                lat1 = raw_coord();
                lon1 = raw_coord();
            end
            6: begin
                span = $urandom_range(0, 20);
                lat1 = lat0 + small_offset(span);
                lon1 = lon0 + small_offset(span);
            end
            7: begin
                if ($urandom_range(0, 1)) lat1 = lat0;
                else lon1 = lon0;
            end
            8: begin
                lat1 = lat0;
                lon1 = lon0;
            end
            9: begin
                lat0 = corner_coord();
                lon0 = corner_coord();
                lat1 = corner_coord();
                lon1 = corner_coord();
            end
            default: ;
        endcase
        send_pair(lat0, lon0, lat1, lon1);
    endtask

    // Drop valid and hold until every awaited result has come back
    task automatic wait_all_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_geometry.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic check_directed_cases();
        feed_gaps_on  = 1'b1;
        drain_gaps_on = 1'b1;
        // coincident points
        send_coords(0, 0, 0, 0);
        send_coords(RANGE_EDGE, -RANGE_EDGE, RANGE_EDGE, -RANGE_EDGE);
        // zero longitude delta, both directions
        send_coords(0, 0, 1000, 0);
        send_coords(0, 0, -1000, 0);
        // zero latitude delta, both directions
        send_coords(0, 0, 0, 1000);
        send_coords(0, 0, 0, -1000);
        // one diagonal per quadrant
        send_coords(0, 0, 1, 1);
        send_coords(0, 0, -1, 1);
        send_coords(0, 0, -1, -1);
        send_coords(0, 0, 1, -1);
        // just off due south, on each side of the half turn
        send_coords(COORD_MAX, 0, COORD_MIN, 1);
        send_coords(COORD_MAX, 0, COORD_MIN, -1);
        // large and full-scale deltas; the first two saturate the distance
        send_coords(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_coords(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_coords(-RANGE_EDGE, -RANGE_EDGE, RANGE_EDGE, RANGE_EDGE);
        send_coords(RANGE_EDGE, -RANGE_EDGE, -RANGE_EDGE, RANGE_EDGE);
        send_coords(0, 0, COORD_MAX, 0);
        send_coords(0, 0, 0, COORD_MIN);
        send_coords(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN);
        // small deltas and root rounding
        send_coords(5, 7, 2, 3);
        send_coords(0, 0, 1, 2);
        send_coords(-1, -1, 0, 0);
        wait_all_results();
    endtask

    // Hold the output off long enough for the unit to fill and stall its input
    task automatic check_input_stall_under_hold();
        feed_gaps_on  = 1'b0;
        drain_gaps_on = 1'b0;
        stall_request = HOLD_OFF_CYCLES;
        repeat (HOLD_OFF_PAIRS) send_random_pair();
        wait_all_results();
    endtask

    // Random pairs in four idling phases; pause for a full drain after each
    task automatic check_random_traffic();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            feed_gaps_on  = (phase == 0 || phase == 2);
            drain_gaps_on = (phase == 0 || phase == 3);
            repeat (PAIRS_PER_PHASE) send_random_pair();
            wait_all_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random ready gaps, long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (stall_request > 0) begin
                gap = stall_request;
                stall_request = 0;
                long_stalls++;
            end else begin
                gap = draw_gap(drain_gaps_on);
            end
            @(negedge clk);
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Compare each result transaction with the oldest awaited one
    always @(posedge clk) begin
        t_geometry want;
        if (rst_n && out_ready && out_valid !== 1'b0) begin
            if (awaited_geometry.size() == 0) begin
                report_error($sformatf("unexpected result: separation %0d heading %0d",
                                       separation, heading_degrees));
            end else begin
                want = awaited_geometry.pop_front();
                if (separation !== want.separation)
                    report_error($sformatf("(%0d,%0d)->(%0d,%0d) separation %0d, want %0d",
                                           want.lat0, want.lon0, want.lat1, want.lon1,
                                           separation, want.separation));
                if (heading_degrees !== want.heading)
                    report_error($sformatf("(%0d,%0d)->(%0d,%0d) heading %0d, want %0d",
                                           want.lat0, want.lon0, want.lat1, want.lon1,
                                           heading_degrees, want.heading));
                if (want.separation == SEP_CEIL) saturated++;
                results_checked++;
            end
        end
    end

    // Count stall cycles; end the run when nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_ready) backpressure_cycles++;
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d results awaited",
                         quiet_cycles, awaited_geometry.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        first_latitude   = '0;
        first_longitude  = '0;
        second_latitude  = '0;
        second_longitude = '0;
        feed_gaps_on     = 1'b1;
        drain_gaps_on    = 1'b1;
        stall_request    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_directed_cases();
        check_input_stall_under_hold();
        check_random_traffic();

        // let any stray result show up
        repeat (FLUSH_CYCLES) @(posedge clk);
        $display("covered %0d point pairs (corners, axes, saturation, random mix), %0d results",
                 pairs_sent, results_checked);
        $display("input held off %0d cycles, %0d long output holds, %0d saturated distances",
                 backpressure_cycles, long_stalls, saturated);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
